@@ rtl/sapq_pkg.sv @@
// Package: sizes, status and kind codes, and cell control types for the priority queue.
package sapq_pkg;

    // Number of cells in the chain
    localparam int DEPTH = 8;
    // Entry count width, wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int HELD_W = 4;
    localparam int STATUS_W = 2;

    // Item kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // Broadcast to every cell in the cycle an item is accepted
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [VAL_W-1:0] val;
    } cell_ctl_t;

    // Where a cell sits relative to the held entries
    typedef struct packed {
        logic occupied;
        logic tail;
    } cell_pos_t;

endpackage

@@ rtl/sapq_ifs.sv @@
// Interfaces: request and response channels of the priority queue.
interface sapq_req_if
    import sapq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sapq_rsp_if
    import sapq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VAL_W-1:0]    out_value;
    logic        [STATUS_W-1:0] status;
    logic        [HELD_W-1:0]   held;

    modport source (output valid, output out_value, output status, output held, input ready);
    modport sink   (input valid, input out_value, input status, input held, output ready);
endinterface

@@ rtl/sapq_cell.sv @@
// One queue cell: holds an entry, compares it with an inserted value, shifts with neighbors.
module sapq_cell
    import sapq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  cell_pos_t               pos,
    input  logic signed [VAL_W-1:0] left_val,
    input  logic                    left_ge,
    input  logic signed [VAL_W-1:0] right_val,
    output logic signed [VAL_W-1:0] entry,
    output logic                    ge
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;

    // Held entry at or above the inserted value: it moves one place right
    assign ge = pos.occupied && (entry_reg >= ctl.val);
    assign entry = entry_reg;

    // Next entry: shift left on dequeue, shift right or take the new value on enqueue
    always_comb
    begin
        priority if (ctl.deq)
        begin
            entry_next = right_val;
        end
        else if (ctl.enq && left_ge)
        begin
            entry_next = left_val;
        end
        else if (ctl.enq && (ge || pos.tail))
        begin
            entry_next = ctl.val;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/sorted_array_min_priority_queue.sv @@
// Top level: minimum-first priority queue built as a chain of sorted cells.
//
//   channel | dir | fields                    | accepted when
//   req     | in  | kind, value               | req.valid && req.ready
//   rsp     | out | out_value, status, held   | rsp.valid && rsp.ready
//
// Every cell compares its entry with the new value at once and all cells shift
// together, so the 32-bit compare in a cell sets the pace. The result lands in
// an output register; a new item is accepted while that register is empty or
// being drained, so one item per cycle is sustained while rsp.ready stays high.
// Reset empties the queue (count zero) and clears the output valid; cells hold
// no reset. A stalled response holds req.ready low.
module sorted_array_min_priority_queue
    import sapq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sapq_req_if.sink          req,
    sapq_rsp_if.source        rsp
);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic signed [VAL_W-1:0]   out_value_reg;
    logic signed [VAL_W-1:0]   out_value_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [HELD_W-1:0]         held_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    cell_ctl_t                 ctl;

    logic signed [VAL_W-1:0]   cell_val [DEPTH];
    logic                      cell_ge  [DEPTH];

    // Handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // Cell control, only on operations that change the queue
    assign ctl.enq = accept && (req.kind == KIND_ENQ) && !full;
    assign ctl.deq = accept && (req.kind == KIND_DEQ) && !empty;
    assign ctl.val = req.value;

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        cell_pos_t               pos;
        logic signed [VAL_W-1:0] lv;
        logic                    lg;
        logic signed [VAL_W-1:0] rv;

        assign pos.occupied = (CNT_W'(g) < count_reg);
        assign pos.tail     = (CNT_W'(g) == count_reg);

        if (g == 0)
        begin : g_head
            assign lv = '0;
            assign lg = 1'b0;
        end
        else
        begin : g_body
            assign lv = cell_val[g-1];
            assign lg = cell_ge[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign rv = '0;
        end
        else
        begin : g_inner
            assign rv = cell_val[g+1];
        end

        sapq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .pos       (pos),
            .left_val  (lv),
            .left_ge   (lg),
            .right_val (rv),
            .entry     (cell_val[g]),
            .ge        (cell_ge[g])
        );
    end

    // Next count and result fields
    always_comb
    begin
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = STATUS_OK;
        if (ctl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.deq)
        begin
            count_next     = count_reg - CNT_W'(1);
            out_value_next = cell_val[0];
        end
        else if (accept && (req.kind == KIND_ENQ))
        begin
            status_next = STATUS_OVERFLOW;
        end
        else if (accept)
        begin
            status_next = STATUS_UNDERFLOW;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            held_reg      <= HELD_W'(count_next);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.status    = status_reg;
    assign rsp.held      = held_reg;

`ifndef SYNTH
    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A successful insert grows the queue by one
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow count");

    // A pending result reports the current count
    a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (held_reg == HELD_W'(count_reg)))
        else $error("held field out of step with count");

    // Overflow is reported only with a full queue
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STATUS_OVERFLOW)) |-> full)
        else $error("overflow without full queue");
`endif

endmodule

@@ tb/sv/sapq_checker.sv @@
// Checker: watches both channels, predicts each result of the queue and compares it.
module sapq_checker
    import sapq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sapq_req_if  req,
    sapq_rsp_if  rsp,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   overflow_seen,
    output int   underflow_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VAL_W-1:0]    out_value;
        logic        [STATUS_W-1:0] status;
        logic        [HELD_W-1:0]   held;
    } pq_result_t;

    // Shadow copy of the queue: ascending, valid in slots 0..held_count-1
    logic signed [VAL_W-1:0] sorted_vals [DEPTH];
    int                      held_count = 0;

    pq_result_t pending_results [$];

    int fails      = 0;
    int n_pending  = 0;
    int n_results  = 0;
    int n_overflow = 0;
    int n_underflow = 0;

    assign fail_count     = fails;
    assign pending        = n_pending;
    assign results_seen   = n_results;
    assign overflow_seen  = n_overflow;
    assign underflow_seen = n_underflow;

    // Apply one item to the shadow queue and return the result it should produce
    function automatic pq_result_t predict_queue_op(logic kind, logic signed [VAL_W-1:0] v);
        pq_result_t r;
        int         i;
        r.out_value = '0;
        r.status    = STATUS_OK;
        if (kind == KIND_ENQ) begin
            if (held_count >= DEPTH) begin
                r.status = STATUS_OVERFLOW;
            end
            else begin
                // new value goes ahead of every entry >= it, so ties leave last-in first
                i = held_count;
                while (i > 0 && sorted_vals[i-1] >= v) begin
                    sorted_vals[i] = sorted_vals[i-1];
                    i--;
                end
                sorted_vals[i] = v;
                held_count++;
            end
        end
        else begin
            if (held_count == 0) begin
                r.status = STATUS_UNDERFLOW;
            end
            else begin
                r.out_value = sorted_vals[0];
                for (i = 1; i < held_count; i++)
                    sorted_vals[i-1] = sorted_vals[i];
                held_count--;
            end
        end
        r.held = HELD_W'(held_count);
        return r;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Results leave before the item accepted on the same edge can produce one
    always @(posedge clk or negedge rst_n) begin
        pq_result_t want;
        if (!rst_n) begin
            held_count = 0;
            pending_results.delete();
            n_pending = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                n_results++;
                if (rsp.status == STATUS_OVERFLOW)
                    n_overflow++;
                if (rsp.status == STATUS_UNDERFLOW)
                    n_underflow++;
                if (pending_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got value %0d status %0d held %0d",
                             $time, rsp.out_value, rsp.status, rsp.held);
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("out_value", want.out_value, rsp.out_value);
                    check_field("status", want.status, rsp.status);
                    check_field("held", want.held, rsp.held);
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(predict_queue_op(req.kind, req.value));
            n_pending = pending_results.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: clock, reset, item stimulus, response stalls and the verdict.
module testbench;
    import sapq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int BLOCK_LEN    = 60;
    localparam int MAX_CYCLES   = 400000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int HOLD_OFF     = 80;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic clk;
    logic rst_n;

    sapq_req_if req_ch ();
    sapq_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int overflow_seen;
    int underflow_seen;

    int items_sent = 0;
    int enq_sent   = 0;
    int deq_sent   = 0;
    int cycle_count = 0;

    sorted_array_min_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sapq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .overflow_seen  (overflow_seen),
        .underflow_seen (underflow_seen)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one item after a random gap; stretches of back-to-back items now and then
    task automatic send_item(input logic k, input logic signed [VAL_W-1:0] v);
        int gap;
        gap = (items_sent % 300 >= 220) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        if (k == KIND_ENQ)
            enq_sent++;
        else
            deq_sent++;
    endtask

    // Mix of full-range, narrow (many ties) and extreme values
    function automatic logic signed [VAL_W-1:0] draw_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 8)) - 4;
            2: v = ($urandom_range(0, 1) != 0) ? VAL_MIN + $urandom_range(0, 2)
                                              : VAL_MAX - $urandom_range(0, 2);
            default: v = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return v;
    endfunction

    // Response side: random stalls, two long hold-offs to back up the queue
    initial
    begin
        int served;
        int pause;
        served = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (served == 40 || served == 800)
                pause = HOLD_OFF;
            else if (served % 250 >= 190)
                pause = 0;
            else
                pause = $urandom_range(0, 14);
            if (pause > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            served++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic signed [VAL_W-1:0] fill_vals [DEPTH];
        int enq_pct;
        int drain;
        int leftover;

        fill_vals = '{VAL_MIN, VAL_MAX, 0, -1, 1, -1, VAL_MAX, VAL_MIN};
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_ENQ;
        req_ch.value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on empty, fill with extremes and ties, overflow, drain, underflow again
        send_item(KIND_DEQ, VAL_MAX);
        for (int i = 0; i < DEPTH; i++)
            send_item(KIND_ENQ, fill_vals[i]);
        send_item(KIND_ENQ, 5);
        send_item(KIND_ENQ, VAL_MIN);
        for (int i = 0; i < DEPTH; i++)
            send_item(KIND_DEQ, -1);
        send_item(KIND_DEQ, VAL_MIN);

        // Random: blocks biased toward filling, mixed, draining, or with a random mix
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / BLOCK_LEN) % 4)
                0: enq_pct = 80;
                1: enq_pct = 50;
                2: enq_pct = 20;
                default: enq_pct = $urandom_range(0, 100);
            endcase
            if ($urandom_range(0, 99) < enq_pct)
                send_item(KIND_ENQ, draw_value());
            else
                send_item(KIND_DEQ, $urandom);
        end
        req_ch.valid <= 1'b0;

        // Wait for outstanding results, then keep idling to catch strays
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        leftover = pending;
        if (leftover != 0)
            $display("%0t: %0d expected results never arrived", $time, leftover);

        $display("Run covered %0d items (%0d enqueue, %0d dequeue) in %0d cycles.",
                 items_sent, enq_sent, deq_sent, cycle_count);
        $display("%0d results checked: %0d overflow, %0d underflow, %0d failures.",
                 results_seen, overflow_seen, underflow_seen, fail_count + leftover);
        if (fail_count == 0 && leftover == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sorted_array_min_priority_queue.f @@
rtl/sapq_pkg.sv
rtl/sapq_ifs.sv
rtl/sapq_cell.sv
rtl/sorted_array_min_priority_queue.sv
tb/sv/sapq_checker.sv
tb/sv/testbench.sv
